/* src/page_frame_allocator_assert.svh */
// assertion macros shared by the page frame allocator modules
`ifndef PAGE_FRAME_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define PFA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked at every edge, reset included
`define PFA_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define PFA_ASSERT(label, prop, msg)
`define PFA_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* src/pfa_pkg.sv */
// types, constants and control bundles of the page frame allocator
`default_nettype none

package pfa_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int ID_WIDTH   = 8;
  localparam int MAX_GRANT  = 16;
  localparam int IDX_W      = $clog2(NUM_FRAMES);
  localparam int CNT_W      = $clog2(NUM_FRAMES + 1);

  localparam int PID_W   = 8;
  localparam int PAGES_W = 5;
  localparam int FIDX_W  = 4;
  localparam int FREED_W = 5;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_MEM  = 2'd1,
    ST_BAD_ID  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    EMIT_NONE  = 3'd0,
    EMIT_BAD   = 3'd1,
    EMIT_EMPTY = 3'd2,
    EMIT_NOMEM = 3'd3,
    EMIT_FREED = 3'd4,
    EMIT_GRANT = 3'd5
  } emit_e;

  typedef struct packed {
    logic               req_type;
    logic [PID_W-1:0]   program_id;
    logic [PAGES_W-1:0] page_count;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               frame_valid;
    logic [FIDX_W-1:0]  frame_index;
    logic [FREED_W-1:0] frames_freed;
    logic               last;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic  load_req;
    logic  step;
    logic  clr_scan;
    logic  cnt_free;
    logic  free_match;
    logic  grant;
    emit_e emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic id_zero;
    logic is_free;
    logic want_zero;
    logic idx_last;
    logic slot_free;
    logic enough;
    logic grant_last;
    logic out_ready;
  } sts_t;

endpackage

`default_nettype wire

/* src/page_frame_allocator.sv */
// top level of the first-fit page frame allocator
// usage:
// - request channel: in_valid_i / in_stall_o carry one req_t beat, an allocate
//   (req_type 0) of page_count frames or a free (req_type 1) of a program's frames
// - result channel: out_valid_o / out_stall_i carry rsp_t beats; an allocate that
//   succeeds gives one beat per granted frame in rising frame order, every other
//   request gives a single beat; the final beat of a request has last set
// - walks: the owner map is walked by one scan pointer, one frame per cycle while
//   no grant waits on the result register
//   - invalid id or zero-page allocate: result written from the check state
//   - free: a scan over all frames, then the result
//   - allocate: a scan counting free frames, then a decision, then a grant walk
//     that stops after the last granted frame
// - one request is worked at a time; the next is taken the cycle after the last
//   result of the previous one is written, even while that result still waits
// - a stalled result holds; the walk pauses on each grant until the result
//   register has room, so stalling only stretches the request
// - reset empties the owner map (every frame free) and the result register
`default_nettype none

module page_frame_allocator (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire pfa_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output pfa_pkg::rsp_t      out_data_o
);

  // command and status bundles between sequencer and datapath
  pfa_pkg::cmd_t cmd;
  pfa_pkg::sts_t sts;

  // sequencer: accept, decide, count, grant and free walks
  pfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // owner map, scan pointer, counter and result register
  pfa_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* src/pfa_datapath.sv */
// owner map, scan pointer, counter, request and result registers
`default_nettype none
`include "page_frame_allocator_assert.svh"

module pfa_datapath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pfa_pkg::req_t in_data_i,
  input  wire pfa_pkg::cmd_t cmd_i,
  output pfa_pkg::sts_t      sts_o,
  input  wire logic          out_stall_i,
  output logic               out_valid_o,
  output pfa_pkg::rsp_t      out_data_o
);

  pfa_pkg::req_t                      req_q;
  logic [pfa_pkg::IDX_W-1:0]          idx_q;
  logic [pfa_pkg::CNT_W-1:0]          cnt_q;
  logic [pfa_pkg::ID_WIDTH-1:0]       owner_q [pfa_pkg::NUM_FRAMES];
  logic                               out_valid_q;
  pfa_pkg::rsp_t                      out_q;
  pfa_pkg::rsp_t                      out_d;
  logic [pfa_pkg::ID_WIDTH-1:0]       id;
  logic [pfa_pkg::ID_WIDTH-1:0]       owner_rd;
  logic                               slot_free;
  logic                               slot_match;
  logic                               out_ready;
  logic [pfa_pkg::CNT_W-1:0]          cnt_inc;

  assign id         = req_q.program_id[pfa_pkg::ID_WIDTH-1:0];
  assign owner_rd   = owner_q[idx_q];
  assign slot_free  = (owner_rd == '0);
  assign slot_match = (owner_rd == id);
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign cnt_inc    = pfa_pkg::CNT_W'(cnt_q + 1'b1);

  always_comb begin
    sts_o.id_zero    = (id == '0);
    sts_o.is_free    = req_q.req_type;
    sts_o.want_zero  = (req_q.page_count == '0);
    sts_o.idx_last   = (idx_q == pfa_pkg::IDX_W'(pfa_pkg::NUM_FRAMES - 1));
    sts_o.slot_free  = slot_free;
    sts_o.enough     = ({1'b0, req_q.page_count} <= 6'(cnt_q)) &&
                       (req_q.page_count <= pfa_pkg::PAGES_W'(pfa_pkg::MAX_GRANT));
    sts_o.grant_last = (6'(cnt_inc) == {1'b0, req_q.page_count});
    sts_o.out_ready  = out_ready;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      cnt_q <= '0;
      for (int i = 0; i < pfa_pkg::NUM_FRAMES; i++) begin
        owner_q[i] <= '0;
      end
    end else begin
      if (cmd_i.clr_scan) begin
        idx_q <= '0;
        cnt_q <= '0;
      end else begin
        if (cmd_i.step) begin
          idx_q <= pfa_pkg::IDX_W'(idx_q + 1'b1);
        end
        if ((cmd_i.cnt_free && slot_free) || (cmd_i.free_match && slot_match) ||
            cmd_i.grant) begin
          cnt_q <= cnt_inc;
        end
      end
      if (cmd_i.free_match && slot_match) begin
        owner_q[idx_q] <= '0;
      end else if (cmd_i.grant) begin
        owner_q[idx_q] <= id;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit != pfa_pkg::EMIT_NONE) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    out_d      = '0;
    out_d.last = 1'b1;
    case (cmd_i.emit)
      pfa_pkg::EMIT_BAD:   out_d.status = pfa_pkg::ST_BAD_ID;
      pfa_pkg::EMIT_NOMEM: out_d.status = pfa_pkg::ST_NO_MEM;
      pfa_pkg::EMIT_FREED: out_d.frames_freed = pfa_pkg::FREED_W'(cnt_q);
      pfa_pkg::EMIT_GRANT: begin
        out_d.frame_valid = 1'b1;
        out_d.frame_index = pfa_pkg::FIDX_W'(idx_q);
        out_d.last        = sts_o.grant_last;
      end
      default: out_d.status = pfa_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit != pfa_pkg::EMIT_NONE) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PFA_ASSERT(a_emit_has_room, cmd_i.emit != pfa_pkg::EMIT_NONE |-> out_ready, "emit into a full result register")
  `PFA_ASSERT(a_grant_free_slot, cmd_i.grant |-> slot_free && !sts_o.id_zero, "grant onto an owned frame")
  `PFA_ASSERT(a_grant_emits, cmd_i.grant == (cmd_i.emit == pfa_pkg::EMIT_GRANT), "grant and its beat disagree")
  `PFA_ASSERT(a_cnt_bound, cnt_q <= pfa_pkg::CNT_W'(pfa_pkg::NUM_FRAMES), "frame counter overran")
  `PFA_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_q, "result valid during reset")

endmodule

`default_nettype wire

/* src/pfa_ctrl.sv */
// request sequencer of the page frame allocator
`default_nettype none

module pfa_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire pfa_pkg::sts_t sts_i,
  output pfa_pkg::cmd_t      cmd_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_COUNT = 7'b0000100,
    S_DEC   = 7'b0001000,
    S_GRANT = 7'b0010000,
    S_FREE  = 7'b0100000,
    S_FDONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.emit = pfa_pkg::EMIT_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          cmd_o.clr_scan = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.id_zero) begin
          if (sts_i.out_ready) begin
            cmd_o.emit = pfa_pkg::EMIT_BAD;
            state_d = S_IDLE;
          end
        end else if (sts_i.is_free) begin
          state_d = S_FREE;
        end else if (sts_i.want_zero) begin
          if (sts_i.out_ready) begin
            cmd_o.emit = pfa_pkg::EMIT_EMPTY;
            state_d = S_IDLE;
          end
        end else begin
          state_d = S_COUNT;
        end
      end
      S_COUNT: begin
        cmd_o.cnt_free = 1'b1;
        cmd_o.step     = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.enough) begin
          cmd_o.clr_scan = 1'b1;
          state_d = S_GRANT;
        end else if (sts_i.out_ready) begin
          cmd_o.emit = pfa_pkg::EMIT_NOMEM;
          state_d = S_IDLE;
        end
      end
      S_GRANT: begin
        if (!sts_i.slot_free) begin
          cmd_o.step = 1'b1;
        end else if (sts_i.out_ready) begin
          cmd_o.grant = 1'b1;
          cmd_o.step  = 1'b1;
          cmd_o.emit  = pfa_pkg::EMIT_GRANT;
          if (sts_i.grant_last) begin
            state_d = S_IDLE;
          end
        end
      end
      S_FREE: begin
        cmd_o.free_match = 1'b1;
        cmd_o.step       = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_FDONE;
        end
      end
      S_FDONE: begin
        if (sts_i.out_ready) begin
          cmd_o.emit = pfa_pkg::EMIT_FREED;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// self-checking testbench of the page frame allocator with an owner map predictor
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS  = 40;

  // request kinds, as carried in req_type
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  logic          clk       = 1'b0;
  logic          rst_n     = 1'b0;
  logic          in_valid  = 1'b0;
  pfa_pkg::req_t in_data   = '0;
  logic          out_stall = 1'b0;
  logic          in_stall;
  logic          out_valid;
  pfa_pkg::rsp_t out_data;

  page_frame_allocator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predicted owner map, 0 marks a free frame
  logic [pfa_pkg::ID_WIDTH-1:0] owner_map [pfa_pkg::NUM_FRAMES];
  // result beats still owed by the block, oldest first
  pfa_pkg::rsp_t                pending_beats [$];

  int mismatch_count   = 0;
  int cycle_count      = 0;
  int beat_count       = 0;
  int alloc_count      = 0;
  int free_count       = 0;
  int bad_id_count     = 0;
  int granted_frames   = 0;
  int nomem_count      = 0;
  int input_held_count = 0;
  int burst_left       = 0;

  // receiver hold-off: set by a test, counted down by the stall process
  bit hold_request = 1'b0;
  int hold_left    = 0;
  int stall_mode   = 0;
  int stall_span   = 0;

  // one line per mismatch, printing capped, counting not
  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] mismatch at beat %0d, %s: got %0d, expected %0d",
               $time, beat_count, what, got, want);
  endtask

  // first-fit allocation and release on the predicted map
  function automatic void predict_request(input pfa_pkg::req_t r);
    logic [pfa_pkg::ID_WIDTH-1:0] pid;
    int            free_frames;
    int            released;
    int            granted;
    int            want;
    pfa_pkg::rsp_t beat;
    pid         = r.program_id[pfa_pkg::ID_WIDTH-1:0];
    want        = r.page_count;
    free_frames = 0;
    released    = 0;
    granted     = 0;
    beat        = '0;
    beat.last   = 1'b1;
    if (pid == '0) begin
      // id zero is refused whatever the request
      beat.status = pfa_pkg::ST_BAD_ID;
      pending_beats.push_back(beat);
      bad_id_count++;
      return;
    end
    if (r.req_type == REQ_FREE) begin
      free_count++;
      for (int i = 0; i < pfa_pkg::NUM_FRAMES; i++) begin
        if (owner_map[i] == pid) begin
          owner_map[i] = '0;
          released++;
        end
      end
      beat.status       = pfa_pkg::ST_OK;
      beat.frames_freed = released[pfa_pkg::FREED_W-1:0];
      pending_beats.push_back(beat);
      return;
    end
    alloc_count++;
    if (want == 0) begin
      beat.status = pfa_pkg::ST_OK;
      pending_beats.push_back(beat);
      return;
    end
    for (int i = 0; i < pfa_pkg::NUM_FRAMES; i++)
      if (owner_map[i] == '0) free_frames++;
    if (free_frames < want || want > pfa_pkg::MAX_GRANT) begin
      // map untouched, single refusal beat
      beat.status = pfa_pkg::ST_NO_MEM;
      pending_beats.push_back(beat);
      nomem_count++;
      return;
    end
    // lowest free frames first, one beat each
    for (int i = 0; i < pfa_pkg::NUM_FRAMES && granted < want; i++) begin
      if (owner_map[i] == '0) begin
        owner_map[i]     = pid;
        beat             = '0;
        beat.status      = pfa_pkg::ST_OK;
        beat.frame_valid = 1'b1;
        beat.frame_index = i[pfa_pkg::FIDX_W-1:0];
        beat.last        = (granted + 1 == want);
        pending_beats.push_back(beat);
        granted++;
      end
    end
    granted_frames += granted;
  endfunction

  // offer one request beat, predict it once taken, then maybe go quiet
  task automatic send_request(input pfa_pkg::req_t r);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    predict_request(r);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 5) == 0)
        repeat ($urandom_range(20, 40)) @(negedge clk);
      else
        repeat ($urandom_range(1, 12)) @(negedge clk);
      // some bursts are long enough to count as stretches with no idling
      if ($urandom_range(0, 4) == 0)
        burst_left = $urandom_range(20, 40);
      else
        burst_left = $urandom_range(0, 8);
    end
  endtask

  // stop offering and wait for every owed beat
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic pfa_pkg::req_t make_request(input logic kind, input int pid,
                                                 input int pages);
    pfa_pkg::req_t r;
    r.req_type   = kind;
    r.program_id = pid[pfa_pkg::PID_W-1:0];
    r.page_count = pages[pfa_pkg::PAGES_W-1:0];
    return r;
  endfunction

  // small pool of owners so frees usually hit something, with a few strays
  function automatic int pick_program_id();
    if ($urandom_range(0, 9) == 0)
      return $urandom_range(1, 255);
    return $urandom_range(1, 6);
  endfunction

  // id zero refused for both kinds, page count ignored
  task automatic test_bad_id();
    send_request(make_request(REQ_ALLOC, 0, 0));
    send_request(make_request(REQ_ALLOC, 0, 31));
    send_request(make_request(REQ_FREE, 0, 16));
    wait_drained();
  endtask

  task automatic test_zero_page();
    send_request(make_request(REQ_ALLOC, 5, 0));
    wait_drained();
  endtask

  // whole map to one owner, then full-map refusal and oversize requests
  task automatic test_alloc_extremes();
    send_request(make_request(REQ_ALLOC, 255, 16));
    send_request(make_request(REQ_ALLOC, 1, 1));
    send_request(make_request(REQ_FREE, 255, 0));
    send_request(make_request(REQ_ALLOC, 7, 17));
    send_request(make_request(REQ_ALLOC, 128, 31));
    send_request(make_request(REQ_FREE, 200, 31));
    wait_drained();
  endtask

  // holes in the map: a grant has to skip owned frames
  task automatic test_fragmented_map();
    send_request(make_request(REQ_ALLOC, 1, 3));
    send_request(make_request(REQ_ALLOC, 2, 4));
    send_request(make_request(REQ_ALLOC, 3, 2));
    send_request(make_request(REQ_FREE, 2, 0));
    send_request(make_request(REQ_ALLOC, 4, 5));
    send_request(make_request(REQ_ALLOC, 9, 16));
    send_request(make_request(REQ_FREE, 1, 0));
    send_request(make_request(REQ_FREE, 3, 0));
    send_request(make_request(REQ_FREE, 4, 0));
    wait_drained();
  endtask

  // receiver holds off long enough for the block to back up into its input
  task automatic test_result_holdoff();
    hold_request = 1'b1;
    for (int k = 0; k < 10; k++) begin
      if (k % 3 == 2)
        send_request(make_request(REQ_FREE, pick_program_id(), 0));
      else
        send_request(make_request(REQ_ALLOC, pick_program_id(), $urandom_range(1, 4)));
    end
    wait_drained();
  endtask

  // mostly well-formed allocate/free traffic, some id zero and raw noise
  task automatic test_random_traffic(input int count);
    pfa_pkg::req_t r;
    int            pick;
    int            size_pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        size_pick = $urandom_range(0, 19);
        if (size_pick < 16)
          r = make_request(REQ_ALLOC, pick_program_id(), $urandom_range(1, 5));
        else if (size_pick == 16)
          r = make_request(REQ_ALLOC, pick_program_id(), 0);
        else if (size_pick == 17)
          r = make_request(REQ_ALLOC, pick_program_id(), $urandom_range(17, 31));
        else
          r = make_request(REQ_ALLOC, pick_program_id(), $urandom_range(6, 16));
      end else if (pick < 88) begin
        r = make_request(REQ_FREE, pick_program_id(), $urandom_range(0, 31));
      end else if (pick < 93) begin
        r = make_request(1'($urandom_range(0, 1)), 0, $urandom_range(0, 31));
      end else begin
        r = pfa_pkg::req_t'($urandom_range(0, (1 << $bits(pfa_pkg::req_t)) - 1));
      end
      send_request(r);
    end
    wait_drained();
  endtask

  // receiver: stall pattern in spans of random mode, or a counted hold-off
  always @(negedge clk) begin
    if (hold_left == 0 && hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      if (stall_span == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_span = $urandom_range(5, 60);
      end
      stall_span--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // result checker: each taken beat against the oldest owed one
  always @(posedge clk) begin
    pfa_pkg::rsp_t want;
    if (rst_n) begin
      if (in_valid && in_stall) input_held_count++;
      if (out_valid && !out_stall) begin
        beat_count++;
        if (pending_beats.size() == 0) begin
          report_mismatch("beat with nothing owed, status", out_data.status, -1);
        end else begin
          want = pending_beats.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.frame_valid !== want.frame_valid)
            report_mismatch("frame_valid", out_data.frame_valid, want.frame_valid);
          if (out_data.frame_index !== want.frame_index)
            report_mismatch("frame_index", out_data.frame_index, want.frame_index);
          if (out_data.frames_freed !== want.frames_freed)
            report_mismatch("frames_freed", out_data.frames_freed, want.frames_freed);
          if (out_data.last !== want.last)
            report_mismatch("last", out_data.last, want.last);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still owed",
               cycle_count, pending_beats.size());
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < pfa_pkg::NUM_FRAMES; i++) owner_map[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_bad_id();
    test_zero_page();
    test_alloc_extremes();
    test_fragmented_map();
    test_result_holdoff();
    test_random_traffic(200);

    // anything arriving now has no owner
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d allocates (%0d refused for space), %0d frees, %0d id-zero requests",
             alloc_count, nomem_count, free_count, bad_id_count);
    $display("checked %0d result beats, %0d frames granted, input held off %0d cycles",
             beat_count, granted_frames, input_held_count);
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
